// ----- src/normalized_fir_convolution_top_assert.svh -----
// assertion macros shared by the convolution engine modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef NORMALIZED_FIR_CONVOLUTION_TOP_ASSERT_SVH
`define NORMALIZED_FIR_CONVOLUTION_TOP_ASSERT_SVH

// checked outside reset
`define NFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked on every edge, reset included
`define NFC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/nfc_pkg.sv -----
// shared types and constants of the normalized convolution engine
// no dependencies
`default_nettype none

package nfc_pkg;

    localparam int NFC_MAX_TAPS = 1024;
    localparam int NFC_KLEN_W   = 11;
    localparam int NFC_SHIFT_W  = 5;
    localparam int NFC_CFG_IW   = 2;
    localparam int NFC_CFG_DW   = 11;
    localparam int NFC_TIDX_W   = 10;
    localparam int NFC_DATA_W   = 16;
    localparam int NFC_VALUE_W  = 32;

    localparam logic [NFC_KLEN_W-1:0]  NFC_KLEN_RST  = 11'd1;
    localparam logic [NFC_SHIFT_W-1:0] NFC_SHIFT_RST = 5'd14;

    localparam logic [NFC_VALUE_W-1:0] NFC_INT32_MAX = 32'h7fff_ffff;
    localparam logic [NFC_VALUE_W-1:0] NFC_INT32_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_TAIL  = 2'd2,
        ACT_START = 2'd3
    } t_action;

    typedef enum logic [NFC_CFG_IW-1:0] {
        CFG_KLEN  = 2'd0,
        CFG_NORM  = 2'd1,
        CFG_SHIFT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic accept_load;
        logic accept_push;
        logic push_zero;
        logic start_run;
        logic mac_step;
        logic div_load;
        logic div_step;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic mac_done;
        logic norm;
        logic tsum_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- src/nfc_ram.sv -----
// generic simple dual port ram, one write and one registered read
// depends on nfc_pkg for default sizes
`default_nettype none

module nfc_ram
    import nfc_pkg::*;
#(
    parameter int WIDTH = NFC_DATA_W,
    parameter int DEPTH = NFC_MAX_TAPS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/nfc_ctrl.sv -----
// controller state machine: accept, multiply-accumulate, divide, deliver
// depends on nfc_pkg and the assertion macro header
`default_nettype none

`include "normalized_fir_convolution_top_assert.svh"

module nfc_ctrl
    import nfc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_action i_action,
    output logic         o_in_stall,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_LOAD: o_cmd.accept_load = 1'b1;
                        ACT_PUSH: begin
                            o_cmd.accept_push = 1'b1;
                            n_state = S_MAC;
                        end
                        ACT_TAIL: begin
                            o_cmd.accept_push = 1'b1;
                            o_cmd.push_zero   = 1'b1;
                            n_state = S_MAC;
                        end
                        ACT_START: o_cmd.start_run = 1'b1;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_st.mac_done) begin
                    if (i_st.norm && !i_st.tsum_zero) begin
                        o_cmd.div_load = 1'b1;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `NFC_ASSERT(a_div_needs_norm, (r_state == S_DIV) |-> i_st.norm, "divide while normalization off")
    `NFC_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE), "not idle after reset")
    `NFC_ASSERT(a_state_onehot, $onehot(r_state), "controller state not one-hot")

endmodule

`default_nettype wire

// ----- src/nfc_dp.sv -----
// datapath: config registers, tap and sample memories, mac pipeline,
// restoring divider, saturation and output register; uses nfc_pkg, nfc_ram
`default_nettype none

`include "normalized_fir_convolution_top_assert.svh"

module nfc_dp
    import nfc_pkg::*;
#(
    parameter int MAX_TAPS = NFC_MAX_TAPS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic        [NFC_CFG_IW-1:0]  i_cfg_index,
    input  wire logic        [NFC_CFG_DW-1:0]  i_cfg_data,
    input  wire logic        [NFC_TIDX_W-1:0]  i_tap_index,
    input  wire logic signed [NFC_DATA_W-1:0]  i_tap_value,
    input  wire logic signed [NFC_DATA_W-1:0]  i_sample,
    input  wire t_cmd                          i_cmd,
    output t_status                            o_st,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed      [NFC_VALUE_W-1:0] o_value,
    output logic                               o_saturated,
    output logic                               o_zero_sum
);

    localparam int AW   = $clog2(MAX_TAPS);
    localparam int CW   = $clog2(MAX_TAPS + 1);
    localparam int LW   = (CW > NFC_KLEN_W) ? CW : NFC_KLEN_W;
    localparam int ACCW = 32 + AW;
    localparam int SUMW = 17 + AW;
    localparam int DCW  = $clog2(ACCW + 1);
    localparam int PW   = 2 * NFC_DATA_W;

    // config
    logic [NFC_KLEN_W-1:0]  r_klen;
    logic                   r_norm;
    logic [NFC_SHIFT_W-1:0] r_oshift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen   <= NFC_KLEN_RST;
            r_norm   <= 1'b1;
            r_oshift <= NFC_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KLEN:  r_klen   <= i_cfg_data;
                CFG_NORM:  r_norm   <= i_cfg_data[0];
                CFG_SHIFT: r_oshift <= i_cfg_data[NFC_SHIFT_W-1:0];
                default:   r_klen   <= r_klen;
            endcase
        end
    end

    // run bookkeeping
    logic [AW-1:0] r_wpos;
    logic [AW-1:0] r_newest;
    logic [CW-1:0] r_nrun;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_nrun;
    logic [LW-1:0] klen_ext;
    logic [CW-1:0] len_c;
    logic [CW-1:0] cnt_c;

    assign klen_ext = LW'(r_klen);
    assign n_nrun   = (r_nrun == CW'(MAX_TAPS)) ? r_nrun : r_nrun + CW'(1);

    always_comb begin
        if (r_klen == '0) begin
            len_c = CW'(1);
        end else if (klen_ext > LW'(MAX_TAPS)) begin
            len_c = CW'(MAX_TAPS);
        end else begin
            len_c = CW'(klen_ext);
        end
        cnt_c = (n_nrun < len_c) ? n_nrun : len_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos  <= '0;
            r_nrun  <= '0;
            r_len   <= '0;
            r_count <= '0;
        end else if (i_cmd.start_run) begin
            r_wpos <= '0;
            r_nrun <= '0;
        end else if (i_cmd.accept_push) begin
            r_wpos  <= (r_wpos == AW'(MAX_TAPS - 1)) ? '0 : r_wpos + AW'(1);
            r_nrun  <= n_nrun;
            r_len   <= len_c;
            r_count <= cnt_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_push) begin
            r_newest <= r_wpos;
        end
    end

    // memories
    logic                  tap_we;
    logic [NFC_DATA_W-1:0] tap_rdata;
    logic [NFC_DATA_W-1:0] smp_rdata;
    logic [NFC_DATA_W-1:0] smp_wdata;
    logic [AW-1:0]         j_a;
    logic [AW:0]           wrap_sum;
    logic [AW-1:0]         smp_raddr;

    assign tap_we    = i_cmd.accept_load && (32'(i_tap_index) < 32'(MAX_TAPS));
    assign smp_wdata = i_cmd.push_zero ? '0 : i_sample;

    logic [CW-1:0] r_j;

    assign j_a       = r_j[AW-1:0];
    assign wrap_sum  = {1'b0, r_newest} + (AW+1)'(MAX_TAPS) - {1'b0, j_a};
    assign smp_raddr = (r_newest >= j_a) ? (r_newest - j_a) : wrap_sum[AW-1:0];

    nfc_ram #(
        .WIDTH (NFC_DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (AW'(i_tap_index)),
        .i_wdata (i_tap_value),
        .i_raddr (j_a),
        .o_rdata (tap_rdata)
    );

    nfc_ram #(
        .WIDTH (NFC_DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept_push),
        .i_waddr (r_wpos),
        .i_wdata (smp_wdata),
        .i_raddr (smp_raddr),
        .o_rdata (smp_rdata)
    );

    // mac pipeline: read, multiply, accumulate
    logic                          issuing;
    logic                          r_v1;
    logic                          r_m1;
    logic                          r_v2;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACCW-1:0]        r_acc;
    logic signed [SUMW-1:0]        r_tsum;
    logic signed [NFC_DATA_W-1:0]  tap_s;
    logic signed [NFC_DATA_W-1:0]  smp_s;

    assign issuing = i_cmd.mac_step && (r_j < r_len);
    assign tap_s   = tap_rdata;
    assign smp_s   = smp_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_j  <= '0;
        end else if (i_cmd.accept_push) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_j  <= '0;
        end else begin
            r_v1 <= issuing;
            r_v2 <= r_v1;
            if (issuing) begin
                r_j <= r_j + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_push) begin
            r_acc  <= '0;
            r_tsum <= '0;
        end else begin
            r_m1 <= issuing && (r_j < r_count);
            if (r_v1) begin
                r_tsum <= r_tsum + SUMW'(tap_s);
                r_prod <= r_m1 ? PW'(tap_s * smp_s) : '0;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACCW'(r_prod);
            end
        end
    end

    // restoring divider on magnitudes
    logic [ACCW-1:0] r_dvd;
    logic [SUMW-1:0] r_dvs;
    logic [SUMW-1:0] r_rem;
    logic            r_neg;
    logic [DCW-1:0]  r_dcnt;
    logic [SUMW:0]   rem_sh;
    logic [SUMW:0]   rem_diff;
    logic            rem_ge;

    assign rem_sh   = {r_rem, r_dvd[ACCW-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign rem_ge   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_load) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= r_acc[ACCW-1] ? ACCW'(-r_acc) : ACCW'(r_acc);
            r_dvs <= r_tsum[SUMW-1] ? SUMW'(-r_tsum) : SUMW'(r_tsum);
            r_rem <= '0;
            r_neg <= r_acc[ACCW-1] ^ r_tsum[SUMW-1];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[SUMW-1:0] : rem_sh[SUMW-1:0];
            r_dvd <= {r_dvd[ACCW-2:0], rem_ge};
        end
    end

    // result formatting and saturation
    logic signed [ACCW-1:0]    shifted;
    logic [ACCW-32:0]          sh_hi;
    logic                      sh_sat;
    logic [NFC_VALUE_W-1:0]    sh_val;
    logic                      pos_ovf;
    logic                      neg_ovf;
    logic                      dv_sat;
    logic [NFC_VALUE_W-1:0]    dv_val;
    logic [NFC_VALUE_W-1:0]    res_val;
    logic                      res_sat;
    logic                      res_zs;
    logic                      tsum_zero;

    assign tsum_zero = (r_tsum == '0);
    assign shifted   = r_acc >>> r_oshift;
    assign sh_hi     = shifted[ACCW-1:31];
    assign sh_sat    = !((sh_hi == '0) || (&sh_hi));
    assign sh_val    = sh_sat ? (shifted[ACCW-1] ? NFC_INT32_MIN : NFC_INT32_MAX)
                              : shifted[31:0];

    assign pos_ovf = |r_dvd[ACCW-1:31];
    assign neg_ovf = (|r_dvd[ACCW-1:32]) || (r_dvd[31] && (|r_dvd[30:0]));
    assign dv_sat  = r_neg ? neg_ovf : pos_ovf;
    assign dv_val  = dv_sat ? (r_neg ? NFC_INT32_MIN : NFC_INT32_MAX)
                            : (r_neg ? -r_dvd[31:0] : r_dvd[31:0]);

    always_comb begin
        if (!r_norm) begin
            res_val = sh_val;
            res_sat = sh_sat;
            res_zs  = 1'b0;
        end else if (tsum_zero) begin
            res_val = '0;
            res_sat = 1'b0;
            res_zs  = 1'b1;
        end else begin
            res_val = dv_val;
            res_sat = dv_sat;
            res_zs  = 1'b0;
        end
    end

    // output register
    logic                   r_out_valid;
    logic [NFC_VALUE_W-1:0] r_value;
    logic                   r_saturated;
    logic                   r_zero_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_value     <= res_val;
            r_saturated <= res_sat;
            r_zero_sum  <= res_zs;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_saturated = r_saturated;
    assign o_zero_sum  = r_zero_sum;

    assign o_st.mac_done  = (r_j == r_len) && !r_v1 && !r_v2;
    assign o_st.norm      = r_norm;
    assign o_st.tsum_zero = tsum_zero;
    assign o_st.div_done  = (r_dcnt == DCW'(ACCW));
    assign o_st.out_free  = !r_out_valid || !i_out_stall;

    `NFC_ASSERT(a_res_load_free, i_cmd.res_load |-> (!r_out_valid || !i_out_stall), "result overwrites pending transfer")
    `NFC_ASSERT(a_div_after_drain, i_cmd.div_load |-> (!r_v1 && !r_v2), "divide starts before mac pipe drained")
    `NFC_ASSERT(a_wpos_range, {1'b0, r_wpos} < (AW+1)'(MAX_TAPS), "write position out of range")

endmodule

`default_nettype wire

// ----- src/normalized_fir_convolution_top.sv -----
// Normalized convolution engine top: controller and datapath
// Tap load and run start are taken while idle and give no result. A push or tail
// transfer gives its result after a multiply-accumulate over the kernel taps, plus a
// bit-serial restoring division when normalization is on and the tap sum is nonzero.
// Throughput: one item at a time, set by the single multiply-accumulate over taps.
// Reset (sync, active low) clears control, run counters and config; memories keep data.
`default_nettype none

module normalized_fir_convolution_top
    import nfc_pkg::*;
#(
    parameter int MAX_TAPS = NFC_MAX_TAPS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic        [NFC_CFG_IW-1:0]  i_cfg_index,
    input  wire logic        [NFC_CFG_DW-1:0]  i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic        [1:0]             i_action,
    input  wire logic        [NFC_TIDX_W-1:0]  i_tap_index,
    input  wire logic signed [NFC_DATA_W-1:0]  i_tap_value,
    input  wire logic signed [NFC_DATA_W-1:0]  i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed      [NFC_VALUE_W-1:0] o_value,
    output logic                               o_saturated,
    output logic                               o_zero_sum
);

    t_cmd    cmd;
    t_status st;

    nfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (t_action'(i_action)),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    nfc_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tap_index (i_tap_index),
        .i_tap_value (i_tap_value),
        .i_sample    (i_sample),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_saturated (o_saturated),
        .o_zero_sum  (o_zero_sum)
    );

endmodule

`default_nettype wire
